[design/dtt_pkg.sv]
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and codes for the deadline task table
// Request/response word layouts, request kinds, status codes, slot entry.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int unsigned SlotsDef = 16;
  localparam int unsigned IdW      = 31;
  localparam int unsigned TimeW    = 32;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_RSVD   = 2'd3
  } req_kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_NONE_DUE = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [TimeW-1:0] deadline;
    logic [IdW-1:0]   cancel_id;
    logic [TimeW-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [IdW-1:0] task_id;
  } rsp_t;

  // one table entry as held in the slot RAM
  typedef struct packed {
    logic [TimeW-1:0] deadline;
    logic [IdW-1:0]   id;
  } slot_t;

endpackage

[design/deadline_task_table.sv]
// ----------------------------------------------------------------------------
// deadline_task_table: pending-task table with deadline firing
// Add / cancel / tick requests over a table of Slots entries, scanned
// one slot per cycle through a single slot RAM.
// ----------------------------------------------------------------------------
// Usage: each request word gives exactly one response word. An add stores
// its deadline under the running id (which wraps at 2^31) and answers with
// that id; if the id is already held after a wrap, that entry is
// overwritten, else the lowest free slot is used, else status full. A cancel
// removes the entry with cancel_id and echoes the id. A tick fires the valid
// entry with the lowest id whose deadline <= now_time (unsigned), removes it
// and returns its id, or answers nothing-due. The unused request kind gets
// nothing-due. Add, cancel and tick each run a scan that reads the slot
// RAM one entry per cycle through its single read port, checks each word
// as it returns from the registered read, then closes the scan and commits;
// the unused kind skips the scan. The commit waits while a previous
// response word is still stalled at the output. The input is stalled
// while a request is in work, so a new request is taken only after the
// commit; the response register lets the next request in while the
// previous response still waits to be taken. Valid bits live in flops
// and clear on reset, so no clearing pass is needed.
module deadline_task_table
  import dtt_pkg::*;
#(
  parameter int unsigned Slots = SlotsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_word_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_word_o
);

  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CntW = $clog2(Slots + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(Slots);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e            state_q;
  req_t              req_q;
  logic [CntW-1:0]   cnt_q;
  logic              rd_pend_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              found_q;
  logic [IdxW-1:0]   found_idx_q;
  logic              free_q;
  logic [IdxW-1:0]   free_idx_q;
  logic [IdW-1:0]    best_id_q;
  logic [Slots-1:0]  valid_q;
  logic [IdW-1:0]    next_id_q;
  logic              out_valid_q;
  rsp_t              out_word_q;

  logic [$bits(slot_t)-1:0] ram_rdata;
  slot_t                    rd_slot;
  slot_t                    wr_slot;
  logic                     rd_vld;
  logic [IdW-1:0]           key;
  logic                     hit_eq;
  logic                     hit_due;
  logic                     out_free;
  logic                     rsp_load;
  logic                     add_ok;
  logic [IdxW-1:0]          add_slot;
  logic                     ram_we;
  rsp_t                     rsp_d;

  assign rd_slot = slot_t'(ram_rdata);
  assign rd_vld  = valid_q[rd_idx_q];

  // shared compare unit: key match for add/cancel, due-and-older for tick
  assign key     = (req_q.req_type == REQ_ADD) ? next_id_q : req_q.cancel_id;
  assign hit_eq  = rd_vld && (rd_slot.id == key);
  assign hit_due = rd_vld && (rd_slot.deadline <= req_q.now_time) &&
                   (!found_q || (rd_slot.id < best_id_q));

  assign out_free = !out_valid_q || !out_stall_i;
  assign rsp_load = (state_q == S_DONE) && out_free;
  assign add_ok   = found_q || free_q;
  assign add_slot = found_q ? found_idx_q : free_idx_q;

  // response built from the scan result
  always_comb begin
    rsp_d.status  = ST_NONE_DUE;
    rsp_d.task_id = '0;
    case (req_q.req_type)
      REQ_ADD: begin
        if (add_ok) begin
          rsp_d.status  = ST_OK;
          rsp_d.task_id = next_id_q;
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      REQ_CANCEL: begin
        rsp_d.task_id = req_q.cancel_id;
        rsp_d.status  = found_q ? ST_OK : ST_NOTFOUND;
      end
      REQ_TICK: begin
        if (found_q) begin
          rsp_d.status  = ST_OK;
          rsp_d.task_id = best_id_q;
        end
      end
      default: begin
        rsp_d.status = ST_NONE_DUE;
      end
    endcase
  end

  assign ram_we = (state_q == S_DONE) && out_free &&
                  (req_q.req_type == REQ_ADD) && add_ok;
  assign wr_slot.deadline = req_q.deadline;
  assign wr_slot.id       = next_id_q;

  dtt_ram #(
    .Width($bits(slot_t)),
    .Depth(Slots)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(add_slot),
    .wdata_i(wr_slot),
    .raddr_i(cnt_q[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      best_id_q   <= '0;
      valid_q     <= '0;
      next_id_q   <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      // a new response word replaces one being taken in the same cycle
      if (rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q     <= in_word_i;
            cnt_q     <= '0;
            rd_pend_q <= 1'b0;
            found_q   <= 1'b0;
            free_q    <= 1'b0;
            case (in_word_i.req_type) inside
              REQ_ADD, REQ_CANCEL, REQ_TICK: state_q <= S_SCAN;
              default:                       state_q <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          // issue one RAM read per cycle, check the returned word in the next cycle
          if (cnt_q < LastCnt) begin
            cnt_q     <= cnt_q + 1'b1;
            rd_pend_q <= 1'b1;
            rd_idx_q  <= cnt_q[IdxW-1:0];
          end else begin
            rd_pend_q <= 1'b0;
            if (!rd_pend_q) begin
              state_q <= S_DONE;
            end
          end
          if (rd_pend_q) begin
            case (req_q.req_type)
              REQ_ADD: begin
                if (hit_eq) begin
                  found_q     <= 1'b1;
                  found_idx_q <= rd_idx_q;
                end
                if (!rd_vld && !free_q) begin
                  free_q     <= 1'b1;
                  free_idx_q <= rd_idx_q;
                end
              end
              REQ_CANCEL: begin
                if (hit_eq) begin
                  found_q     <= 1'b1;
                  found_idx_q <= rd_idx_q;
                end
              end
              REQ_TICK: begin
                if (hit_due) begin
                  found_q     <= 1'b1;
                  found_idx_q <= rd_idx_q;
                  best_id_q   <= rd_slot.id;
                end
              end
              default: begin
                found_q <= found_q;
              end
            endcase
          end
        end
        S_DONE: begin
          // commit only when the response register can take the word
          if (out_free) begin
            out_word_q  <= rsp_d;
            state_q     <= S_IDLE;
            case (req_q.req_type) inside
              REQ_ADD: begin
                if (add_ok) begin
                  valid_q[add_slot] <= 1'b1;
                  next_id_q         <= next_id_q + 1'b1;
                end
              end
              REQ_CANCEL, REQ_TICK: begin
                if (found_q) begin
                  valid_q[found_idx_q] <= 1'b0;
                end
              end
              default: begin
                valid_q <= valid_q;
              end
            endcase
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[design/dtt_ram.sv]
// ----------------------------------------------------------------------------
// dtt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[test/deadline_task_table_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_task_table_checker: response predictor and scoreboard
// Watches both channels of the task table, keeps its own copy of the slot
// table, predicts one response word per accepted request word and compares
// each accepted response word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module deadline_task_table_checker
  import dtt_pkg::*;
#(
  parameter int unsigned Slots = SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  req_t        in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  rsp_t        out_word_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned fired_o
);

  // shadow of the slot table
  logic             live     [Slots];
  logic [TimeW-1:0] due_at   [Slots];
  logic [IdW-1:0]   owner_id [Slots];
  logic [IdW-1:0]   id_ctr;

  rsp_t        expected_rsp_q[$];
  rsp_t        oldest_rsp;
  int unsigned fails;
  int unsigned checked;
  int unsigned fired;

  // applies one request to the shadow table and returns its response word
  function automatic rsp_t table_apply(req_t w);
    rsp_t r;
    int   hit;
    r.status  = ST_NONE_DUE;
    r.task_id = '0;
    hit       = -1;
    case (req_kind_e'(w.req_type))
      REQ_ADD: begin
        // an id still held after a wrap is overwritten in place
        for (int i = 0; i < Slots; i++) begin
          if (hit < 0 && live[i] && owner_id[i] == id_ctr) hit = i;
        end
        for (int i = 0; i < Slots; i++) begin
          if (hit < 0 && !live[i]) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_FULL;
        end else begin
          live[hit]     = 1'b1;
          due_at[hit]   = w.deadline;
          owner_id[hit] = id_ctr;
          r.status      = ST_OK;
          r.task_id     = id_ctr;
          id_ctr        = id_ctr + 1'b1;
        end
      end
      REQ_CANCEL: begin
        r.task_id = w.cancel_id;
        for (int i = 0; i < Slots; i++) begin
          if (hit < 0 && live[i] && owner_id[i] == w.cancel_id) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          live[hit] = 1'b0;
          r.status  = ST_OK;
        end
      end
      REQ_TICK: begin
        // lowest id among the due entries, not lowest slot
        for (int i = 0; i < Slots; i++) begin
          if (live[i] && due_at[i] <= w.now_time &&
              (hit < 0 || owner_id[i] < owner_id[hit])) hit = i;
        end
        if (hit >= 0) begin
          live[hit] = 1'b0;
          r.status  = ST_OK;
          r.task_id = owner_id[hit];
          fired++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) live[i] = 1'b0;
      id_ctr = '0;
      expected_rsp_q.delete();
      fails   = 0;
      checked = 0;
      fired   = 0;
    end else begin
      if (in_valid_i && !in_stall_i) expected_rsp_q.push_back(table_apply(in_word_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response word with nothing expected: status %0d task_id %0d",
                 out_word_i.status, out_word_i.task_id);
          fails++;
        end else begin
          oldest_rsp = expected_rsp_q.pop_front();
          checked++;
          if (out_word_i.status !== oldest_rsp.status) begin
            $error("status: expected %0d, got %0d", oldest_rsp.status, out_word_i.status);
            fails++;
          end
          if (out_word_i.task_id !== oldest_rsp.task_id) begin
            $error("task_id: expected %0d, got %0d", oldest_rsp.task_id,
                   out_word_i.task_id);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_rsp_q.size();
    checked_o    <= checked;
    fired_o      <= fired;
  end

endmodule

[test/deadline_task_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_task_table_tb: request stimulus and verdict for the task table
// Directed corner words (empty and full table, extreme times and ids,
// unknown cancels, the unused request kind) followed by random add, cancel
// and tick traffic under four mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module deadline_task_table_tb;
  import dtt_pkg::*;

  // longest quiet stretch allowed before the run is declared hung
  localparam int unsigned WatchdogLimit = 4000;
  // settle time after the last response, sized from the slot count
  localparam int unsigned DrainCycles   = 2 * (SlotsDef + 3) + 8;
  localparam int unsigned RandomWords   = 1625;
  localparam int unsigned Segments      = 8;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  req_t in_word   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_word;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned fired;

  // idling mix, percent of cycles
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  int unsigned idle_cycles = 0;
  int unsigned n_add, n_cancel, n_tick, n_rsvd;

  // stimulus-side bookkeeping: rough id counter and a running clock
  logic [IdW-1:0]   adds_sent = '0;
  logic [TimeW-1:0] wall_sec  = '0;

  always #5 clk_i = ~clk_i;

  deadline_task_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  deadline_task_table_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .fired_o     (fired)
  );

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // hang detector: counts cycles where neither channel moves a word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // builds a request; fields the kind does not use carry random junk
  function automatic req_t mk_req(req_kind_e kind, logic [TimeW-1:0] dl,
                                  logic [IdW-1:0] cid, logic [TimeW-1:0] now);
    req_t w;
    w.req_type  = kind;
    w.deadline  = (kind == REQ_ADD)    ? dl  : TimeW'($urandom);
    w.cancel_id = (kind == REQ_CANCEL) ? cid : IdW'($urandom);
    w.now_time  = (kind == REQ_TICK)   ? now : TimeW'($urandom);
    return w;
  endfunction

  // presents one word, with optional idle cycles ahead of it, and returns
  // at the falling edge after it was taken; valid stays high on exit
  task automatic send_word(input req_t w);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall;
    end
    @(negedge clk_i);
    case (req_kind_e'(w.req_type))
      REQ_ADD:    begin n_add++; adds_sent = adds_sent + 1'b1; end
      REQ_CANCEL: n_cancel++;
      REQ_TICK:   n_tick++;
      default:    n_rsvd++;
    endcase
  endtask

  // one random word: mostly plausible traffic around the running clock,
  // with a share of wild deadlines, times and ids
  task automatic send_random_word();
    int unsigned      pick;
    logic [TimeW-1:0] dl;
    logic [IdW-1:0]   cid;
    pick = $urandom_range(99);
    if (pick < 40) begin
      dl = ($urandom_range(99) < 10) ? TimeW'($urandom)
                                     : wall_sec + TimeW'($urandom_range(40));
      send_word(mk_req(REQ_ADD, dl, '0, '0));
    end else if (pick < 60) begin
      cid = ($urandom_range(99) < 15) ? IdW'($urandom)
                                      : adds_sent - IdW'($urandom_range(24, 1));
      send_word(mk_req(REQ_CANCEL, '0, cid, '0));
    end else if (pick < 95) begin
      if ($urandom_range(99) < 8) begin
        send_word(mk_req(REQ_TICK, '0, '0, TimeW'($urandom)));
      end else begin
        wall_sec = wall_sec + TimeW'($urandom_range(4));
        send_word(mk_req(REQ_TICK, '0, '0, wall_sec));
      end
    end else begin
      send_word(mk_req(REQ_RSVD, '0, '0, '0));
    end
  endtask

  initial begin
    n_add    = 0;
    n_cancel = 0;
    n_tick   = 0;
    n_rsvd   = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty table, extremes of time, unknown ids, unused kind
    send_word(mk_req(REQ_TICK, '0, '0, '0));                    // nothing due
    send_word(mk_req(REQ_ADD, '0, '0, '0));                     // id 0, due at 0
    send_word(mk_req(REQ_ADD, '1, '0, '0));                     // id 1, due at max
    send_word(mk_req(REQ_TICK, '0, '0, '1 - 1'b1));             // fires id 0
    send_word(mk_req(REQ_TICK, '0, '0, '1 - 1'b1));             // id 1 not yet due
    send_word(mk_req(REQ_CANCEL, '0, '1, '0));                  // unknown id
    send_word(mk_req(REQ_CANCEL, '0, IdW'(1), '0));             // removes id 1
    send_word(mk_req(REQ_RSVD, '1, '1, '1));                    // ignored
    // fill the table with falling deadlines so low ids come due last
    for (int k = 0; k < SlotsDef; k++) begin
      send_word(mk_req(REQ_ADD, TimeW'(1000 - 10 * k), '0, '0));
    end
    send_word(mk_req(REQ_ADD, TimeW'(5), '0, '0));              // table full
    send_word(mk_req(REQ_TICK, '0, '0, TimeW'(920)));           // lowest due id
    send_word(mk_req(REQ_TICK, '0, '0, '1));                    // lowest id overall
    wall_sec = TimeW'(900);

    // random traffic, cycling through the idling mixes
    for (int seg = 0; seg < Segments; seg++) begin
      case (seg % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 65; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      for (int n = 0; n < RandomWords / Segments; n++) send_random_word();
    end

    in_valid  <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d request words: %0d adds, %0d cancels, %0d ticks, %0d unused kind,",
             n_add + n_cancel + n_tick + n_rsvd, n_add, n_cancel, n_tick, n_rsvd);
    $display("under four idle/stall mixes; %0d responses checked, %0d tasks fired.",
             checked, fired);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[deadline_task_table.f]
design/dtt_pkg.sv
design/dtt_ram.sv
design/deadline_task_table.sv
test/deadline_task_table_checker.sv
test/deadline_task_table_tb.sv
